/* rtl/core/bni_pkg.sv */
// bni_pkg: shared types and constants for the batch norm inference block
// no dependencies
package bni_pkg;

  localparam int DataW = 32;
  localparam logic signed [DataW-1:0] SMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SMin = 32'sh80000000;

  typedef enum logic [1:0] {
    REG_EPSILON  = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_PIXELS   = 2'd2
  } reg_idx_e;

  // saturate a signed value of width 66 to 32 bits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [DataW-1:0] r;
    if (v > 66'sd2147483647) begin
      r = SMax;
    end else if (v < -66'sd2147483648) begin
      r = SMin;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // round(v / 2^16), ties away from zero, on a 64-bit signed product
  function automatic logic signed [65:0] round_q16(input logic signed [63:0] v);
    logic [63:0] m;
    logic [64:0] t;
    logic signed [65:0] r;
    m = v[63] ? (64'd0 - v) : v;
    t = {1'b0, m} + 65'h8000;
    r = $signed({17'd0, t[64:16]});
    if (v[63]) begin
      r = -r;
    end
    return r;
  endfunction

endpackage

/* rtl/core/batch_norm_inference.sv */
// batch_norm_inference: top level of the per-channel batch norm block
// depends on bni_pkg, bni_coef, bni_table, bni_datapath
//
// Per-channel batch normalization in signed Q16.16. A load transaction
// (req_type 0) computes scale = gamma/sqrt(var+eps) and shift =
// beta - scale*mean and writes both into the channel's entry of a
// 1-port-write/1-port-read table memory; it produces no result and keeps
// the block busy through the bit-serial square root (32 steps) and
// restoring divider (58 steps) in bni_coef, during which input is stalled.
// A sample transaction (req_type 1) reads the entry of the internal channel
// counter in a registered table read, multiplies and adds shift over two
// more stages, and lands in a one-deep output register. One sample is in
// flight at a time; the next is accepted once the output register is free.
// Channels are innermost (HWC); pixel_last and image_last mark the ends.
// Unloaded channels give undefined results. No clearing pass after reset.
module batch_norm_inference
  import bni_pkg::*;
#(
  parameter int MAX_CHANNELS = 1024,
  parameter int MAX_PIXELS   = 1048576
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config port
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [20:0]             cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [9:0]              channel_index_i,
  input  logic signed [31:0]      gamma_value_i,
  input  logic signed [31:0]      beta_value_i,
  input  logic signed [31:0]      mean_value_i,
  input  logic [30:0]             variance_value_i,
  input  logic signed [31:0]      sample_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [31:0]      normalized_o,
  output logic                    pixel_last_o,
  output logic                    image_last_o
);

  localparam int AW = $clog2(MAX_CHANNELS);
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int PW = $clog2(MAX_PIXELS + 1);

  // config registers
  logic [15:0] eps_q;
  logic [10:0] chn_q;
  logic [20:0] pix_q;

  // counters
  logic [AW-1:0] ch_cnt_q;
  logic [PW-1:0] px_cnt_q;

  // sample pipeline: read, multiply, add; plus output hold
  logic [2:0] stg_q;
  logic [1:0] flag_q [3];
  logic       busy_w;
  logic       out_v_q;
  logic signed [31:0] res_w;
  logic [1:0] flags_q;

  logic coef_busy, coef_done;
  logic signed [31:0] c_scale, c_shift, r_scale, r_shift;
  logic [AW-1:0] ld_idx_q;

  logic acc_w, ld_acc, smp_acc;
  logic [CW-1:0] chn_cl;
  logic [PW-1:0] pix_cl;
  logic plast_w, ilast_w;

  assign acc_w   = in_valid_i && in_ready_o;
  assign ld_acc  = acc_w && !req_type_i;
  assign smp_acc = acc_w && req_type_i;
  assign busy_w  = |stg_q;
  // one item in flight; hold off while the result register is occupied
  assign in_ready_o = !coef_busy && !coef_done && !busy_w && !out_v_q;

  // clamp registers into their legal range when used
  always_comb begin
    if (chn_q == '0) begin
      chn_cl = CW'(1);
    end else if ({21'd0, chn_q} > 32'(MAX_CHANNELS)) begin
      chn_cl = CW'(MAX_CHANNELS);
    end else begin
      chn_cl = CW'(chn_q);
    end
    if (pix_q == '0) begin
      pix_cl = PW'(1);
    end else if ({11'd0, pix_q} > 32'(MAX_PIXELS)) begin
      pix_cl = PW'(MAX_PIXELS);
    end else begin
      pix_cl = PW'(pix_q);
    end
    plast_w = ({1'b0, ch_cnt_q} >= (CW + 1)'(chn_cl - CW'(1)));
    ilast_w = plast_w && ({1'b0, px_cnt_q} >= (PW + 1)'(pix_cl - PW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q    <= 16'd66;
      chn_q    <= 11'd64;
      pix_q    <= 21'd1;
      ch_cnt_q <= '0;
      px_cnt_q <= '0;
      stg_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_EPSILON:  eps_q <= cfg_data_i[15:0];
          REG_CHANNELS: chn_q <= cfg_data_i[10:0];
          REG_PIXELS:   pix_q <= cfg_data_i;
          default: ;
        endcase
      end
      stg_q <= {stg_q[1:0], smp_acc};
      if (stg_q[2]) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (smp_acc) begin
        if (plast_w) begin
          ch_cnt_q <= '0;
          px_cnt_q <= ilast_w ? '0 : PW'(px_cnt_q + PW'(1));
        end else begin
          ch_cnt_q <= AW'(ch_cnt_q + AW'(1));
        end
      end
    end
  end

  // flags travel with the sample; load index held for the write back
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      flag_q[0] <= {plast_w, ilast_w};
    end
    flag_q[1] <= flag_q[0];
    flag_q[2] <= flag_q[1];
    if (stg_q[2]) begin
      flags_q <= flag_q[2];
    end
    if (ld_acc) begin
      // index wraps to the table depth
      ld_idx_q <= AW'(channel_index_i);
    end
  end

  bni_coef u_coef (
    .clk_i, .rst_ni,
    .start_i   (ld_acc),
    .epsilon_i (eps_q),
    .gamma_i   (gamma_value_i),
    .beta_i    (beta_value_i),
    .mean_i    (mean_value_i),
    .variance_i(variance_value_i),
    .busy_o    (coef_busy),
    .done_o    (coef_done),
    .scale_o   (c_scale),
    .shift_o   (c_shift)
  );

  bni_table #(.Depth(MAX_CHANNELS)) u_table (
    .clk_i,
    .we_i    (coef_done),
    .waddr_i (ld_idx_q),
    .wscale_i(c_scale),
    .wshift_i(c_shift),
    .re_i    (smp_acc),
    .raddr_i (ch_cnt_q),
    .rscale_o(r_scale),
    .rshift_o(r_shift)
  );

  // sample held in the read stage alongside the table data
  logic signed [31:0] smp_q;
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      smp_q <= sample_i;
    end
  end

  bni_datapath u_dp (
    .clk_i,
    .en_i    (stg_q[0]),
    .sample_i(smp_q),
    .scale_i (r_scale),
    .shift_i (r_shift),
    .result_o(res_w)
  );

  assign out_valid_o  = out_v_q;
  assign normalized_o = res_w;
  assign pixel_last_o = flags_q[1];
  assign image_last_o = flags_q[0];

  // at most one sample in the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0({stg_q, out_v_q}))
    else $error("more than one sample in flight");
  // a load never overlaps a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni) coef_busy |-> !busy_w)
    else $error("coefficient unit busy during sample");
  // image_last only together with pixel_last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!image_last_o || pixel_last_o))
    else $error("image_last without pixel_last");

endmodule

/* rtl/core/bni_coef.sv */
// bni_coef: turns one channel's gamma/beta/mean/variance into scale and shift
// depends on bni_pkg; bit-serial square root and divider, then one multiply
module bni_coef
  import bni_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [15:0]             epsilon_i,
  input  logic signed [DataW-1:0] gamma_i,
  input  logic signed [DataW-1:0] beta_i,
  input  logic signed [DataW-1:0] mean_i,
  input  logic [30:0]             variance_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [DataW-1:0] scale_o,
  output logic signed [DataW-1:0] shift_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQRT = 6'b000010,
    S_DIV  = 6'b000100,
    S_QSAT = 6'b001000,
    S_MUL  = 6'b010000,
    S_SHFT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;       // sqrt remainder, radicand s<<32
  logic [63:0] rad_q, rad_d;       // radicand shifting out two bits per step
  logic [32:0] root_q, root_d;
  logic [57:0] num_q, num_d;       // 2*|gamma|<<24 + r
  logic [57:0] quo_q, quo_d;
  logic [34:0] drem_q, drem_d;
  logic        gneg_q, gneg_d, gzero_q, gzero_d, szero_q, szero_d;
  logic signed [DataW-1:0] beta_q, beta_d, mean_q, mean_d, scale_q, scale_d;
  logic signed [DataW-1:0] shift_q, shift_d;
  logic signed [63:0] prod_q, prod_d;
  logic        done_q, done_d;

  logic [31:0] s_w;
  logic [31:0] gmag_w;
  logic [65:0] trial_w;
  logic [66:0] rem_sh_w;
  logic [35:0] dsh_w;
  logic [34:0] dvs_w;
  logic [32:0] qmag_w;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rem_d = rem_q; rad_d = rad_q; root_d = root_q;
    num_d = num_q; quo_d = quo_q; drem_d = drem_q; gneg_d = gneg_q; gzero_d = gzero_q;
    szero_d = szero_q; beta_d = beta_q; mean_d = mean_q; scale_d = scale_q;
    shift_d = shift_q; prod_d = prod_q; done_d = 1'b0;
    s_w = {1'b0, variance_i} + {16'd0, epsilon_i};
    gmag_w = gamma_i[31] ? (32'd0 - gamma_i) : gamma_i;
    rem_sh_w = {1'b0, rem_q, rad_q[63:62]};
    trial_w = {root_q, 2'b01};
    dsh_w = {drem_q, num_q[57]};
    dvs_w = {1'b0, root_q, 1'b0};
    qmag_w = (quo_q > 58'h80000000) ? 33'h80000000 : quo_q[32:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rad_d = {s_w, 32'd0};
          rem_d = '0; root_d = '0; cnt_d = 6'd0;
          gneg_d = gamma_i[31]; gzero_d = (gamma_i == '0); szero_d = (s_w == '0);
          num_d = {1'b0, gmag_w, 25'd0};
          beta_d = beta_i; mean_d = mean_i;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // one result bit per cycle, 32 steps
        rad_d = {rad_q[61:0], 2'b00};
        if (rem_sh_w >= {1'b0, trial_w}) begin
          rem_d = 64'(rem_sh_w - {1'b0, trial_w});
          root_d = {root_q[31:0], 1'b1};
        end else begin
          rem_d = rem_sh_w[63:0];
          root_d = {root_q[31:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = S_DIV; cnt_d = 6'd0; drem_d = '0; quo_d = '0;
          num_d = num_q + {25'd0, root_d};
        end
      end
      S_DIV: begin
        // restoring divide by 2r, one quotient bit per cycle, 58 steps
        num_d = {num_q[56:0], 1'b0};
        if (dsh_w >= {1'b0, dvs_w}) begin
          drem_d = 35'(dsh_w - {1'b0, dvs_w});
          quo_d = {quo_q[56:0], 1'b1};
        end else begin
          drem_d = dsh_w[34:0];
          quo_d = {quo_q[56:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd57) begin
          state_d = S_QSAT;
        end
      end
      S_QSAT: begin
        if (szero_q) begin
          scale_d = gzero_q ? '0 : (gneg_q ? SMin : SMax);
        end else begin
          scale_d = sat32(gneg_q ? -$signed({33'd0, qmag_w}) : $signed({33'd0, qmag_w}));
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d = 64'(scale_q * mean_q);
        state_d = S_SHFT;
      end
      S_SHFT: begin
        shift_d = sat32(66'(beta_q) - round_q16(prod_q));
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; rem_q <= rem_d; rad_q <= rad_d; root_q <= root_d; num_q <= num_d;
    quo_q <= quo_d; drem_q <= drem_d; gneg_q <= gneg_d; gzero_q <= gzero_d;
    szero_q <= szero_d; beta_q <= beta_d; mean_q <= mean_d; scale_q <= scale_d;
    shift_q <= shift_d; prod_q <= prod_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign scale_o = scale_q;
  assign shift_o = shift_q;

endmodule

/* rtl/core/bni_table.sv */
// bni_table: per-channel scale and shift memories, one write and one read port
// depends on bni_pkg
module bni_table
  import bni_pkg::*;
#(
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic signed [DataW-1:0]  wscale_i,
  input  logic signed [DataW-1:0]  wshift_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic signed [DataW-1:0]  rscale_o,
  output logic signed [DataW-1:0]  rshift_o
);

  logic [2*DataW-1:0] mem_q [Depth];
  logic [2*DataW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wscale_i, wshift_i};
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rscale_o = rd_q[2*DataW-1:DataW];
  assign rshift_o = rd_q[DataW-1:0];

endmodule

/* rtl/core/bni_datapath.sv */
// bni_datapath: sample times scale plus shift, two registered stages
// depends on bni_pkg
module bni_datapath
  import bni_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [DataW-1:0] sample_i,
  input  logic signed [DataW-1:0] scale_i,
  input  logic signed [DataW-1:0] shift_i,
  output logic signed [DataW-1:0] result_o
);

  logic signed [63:0]      prod_q;
  logic signed [DataW-1:0] shift_q;
  logic signed [DataW-1:0] res_q;
  logic                    en2_q;

  always_ff @(posedge clk_i) begin
    en2_q <= en_i;
    if (en_i) begin
      prod_q  <= 64'(sample_i * scale_i);
      shift_q <= shift_i;
    end
    if (en2_q) begin
      res_q <= sat32(round_q16(prod_q) + 66'(shift_q));
    end
  end

  assign result_o = res_q;

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for the batch_norm_inference block
// depends on bni_pkg and the batch_norm_inference rtl
// random and directed load/sample traffic, checked against an in-bench predictor
module testbench;
  import bni_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumCh = 1024;
  localparam int NumPx = 1048576;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam int CycleLimit = 600000;
  // a load keeps the block busy with no result
  localparam int LoadDrain = 130;

  typedef struct packed {
    logic        req;
    logic [9:0]  chan;
    logic [31:0] gamma;
    logic [31:0] beta;
    logic [31:0] mean;
    logic [30:0] vari;
    logic [31:0] smp;
  } bn_item_t;

  typedef struct packed {
    logic [31:0] norm;
    logic        plast;
    logic        ilast;
  } bn_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_EPSILON;
  logic [20:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] normalized_o;
  logic pixel_last_o, image_last_o;

  bn_item_t cur_item = '0;

  batch_norm_inference u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .req_type_i      (cur_item.req),
    .channel_index_i (cur_item.chan),
    .gamma_value_i   (cur_item.gamma),
    .beta_value_i    (cur_item.beta),
    .mean_value_i    (cur_item.mean),
    .variance_value_i(cur_item.vari),
    .sample_i        (cur_item.smp),
    .out_valid_o, .out_ready_i,
    .normalized_o, .pixel_last_o, .image_last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shared bench state
  bn_item_t   item_q[$];     // transactions waiting to be driven
  bn_result_t norm_q[$];     // normalized results still to come
  bit         quiet = 1'b0;  // no idling on either side when set
  int         err_cnt = 0;
  int         n_loads = 0, n_samples = 0, n_phases = 0;

  // predictor copy of the block state and registers
  longint scale_mem[NumCh];
  longint shift_mem[NumCh];
  int     ch_cnt = 0, px_cnt = 0;
  int     eps_reg = 66, ch_reg = 64, px_reg = 1;

  // generator shadow of the channel counter, to load channels before use
  int gen_ch = 0, gen_px = 0;
  bit loaded[NumCh];

  function automatic int clamp_ch(int v);
    return (v < 1) ? 1 : (v > NumCh) ? NumCh : v;
  endfunction

  function automatic int clamp_px(int v);
    return (v < 1) ? 1 : (v > NumPx) ? NumPx : v;
  endfunction

  function automatic longint sat_s32(longint v);
    return (v > S32Max) ? S32Max : (v < S32Min) ? S32Min : v;
  endfunction

  // divide by 2^16, nearest, ties away from zero
  function automatic longint div_q16(longint v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + 64'h8000) >> 16;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // gamma / sqrt(var + eps) in q16.16
  function automatic longint bn_scale(longint g, logic [63:0] s);
    logic [63:0] r, mag, q;
    if (s == 0) begin
      // zero denominator saturates by the sign of gamma
      return (g > 0) ? S32Max : (g < 0) ? S32Min : 0;
    end
    r = int_sqrt(s << 32);
    mag = ((g < 0) ? 64'(-g) : 64'(g)) << 24;
    q = (2 * mag + r) / (2 * r);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return sat_s32((g < 0) ? -longint'(q) : longint'(q));
  endfunction

  // apply one accepted transaction to the predictor
  function automatic void predict_bn(bn_item_t it);
    longint sc, x;
    int ch_n, px_n;
    bn_result_t res;
    if (!it.req) begin
      sc = bn_scale(longint'($signed(it.gamma)), 64'(it.vari) + 64'(eps_reg));
      scale_mem[it.chan] = sc;
      shift_mem[it.chan] = sat_s32(longint'($signed(it.beta))
                                   - div_q16(sc * longint'($signed(it.mean))));
      return;
    end
    ch_n = clamp_ch(ch_reg);
    px_n = clamp_px(px_reg);
    x = longint'($signed(it.smp));
    res.norm = 32'(sat_s32(div_q16(x * scale_mem[ch_cnt % NumCh]) + shift_mem[ch_cnt % NumCh]));
    // a counter at or past its end (registers shrunk mid-image) counts as last
    res.plast = (ch_cnt >= ch_n - 1);
    res.ilast = res.plast && (px_cnt >= px_n - 1);
    if (res.plast) begin
      ch_cnt = 0;
      px_cnt = res.ilast ? 0 : px_cnt + 1;
    end else begin
      ch_cnt++;
    end
    norm_q.push_back(res);
  endfunction

  // driver: one transaction per handshake, random idle bursts
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_bn(cur_item);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item <= item_q.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  int recv_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bn_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (norm_q.size() == 0) begin
          $error("result with nothing expected: normalized %0d", normalized_o);
          err_cnt++;
        end else begin
          want = norm_q.pop_front();
          if (normalized_o !== want.norm) begin
            $error("normalized: expected %0d actual %0d", $signed(want.norm), normalized_o);
            err_cnt++;
          end
          if (pixel_last_o !== want.plast) begin
            $error("pixel_last: expected %0b actual %0b", want.plast, pixel_last_o);
            err_cnt++;
          end
          if (image_last_o !== want.ilast) begin
            $error("image_last: expected %0b actual %0b", want.ilast, image_last_o);
            err_cnt++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) recv_stall <= $urandom_range(1, 7);
      end
    end
  end

  // watchdog
  int cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("batch_norm_inference: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_var();
    case ($urandom_range(0, 7))
      0: return 31'h0;
      1: return 31'h7fff_ffff;
      2, 3: return 31'($urandom_range(0, 1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic void push_load(int chan, logic [31:0] g, logic [31:0] b,
                                    logic [31:0] m, logic [30:0] v);
    bn_item_t it;
    it = '{req: 1'b0, chan: 10'(chan), gamma: g, beta: b, mean: m, vari: v,
           smp: $urandom};
    item_q.push_back(it);
    loaded[chan] = 1'b1;
    n_loads++;
  endfunction

  // queue a sample, loading its channel first if it was never written
  function automatic void push_sample(logic [31:0] s);
    bn_item_t it;
    int ch_n, px_n;
    if (!loaded[gen_ch]) push_load(gen_ch, pick32(), pick32(), pick32(), pick_var());
    it = '{req: 1'b1, chan: 10'($urandom), gamma: $urandom, beta: $urandom,
           mean: $urandom, vari: 31'($urandom), smp: s};
    item_q.push_back(it);
    n_samples++;
    ch_n = clamp_ch(ch_reg);
    px_n = clamp_px(px_reg);
    if (gen_ch >= ch_n - 1) begin
      gen_px = (gen_px >= px_n - 1) ? 0 : gen_px + 1;
      gen_ch = 0;
    end else begin
      gen_ch++;
    end
  endfunction

  // wait for all traffic to drain, then for a pending load to finish
  task automatic drain_all();
    while (item_q.size() != 0 || in_valid_i || norm_q.size() != 0) @(posedge clk_i);
    repeat (LoadDrain) @(posedge clk_i);
  endtask

  // register writes, only while the block is idle
  task automatic write_regs(int eps, int ch, int px);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_EPSILON;
    cfg_data_i <= 21'(eps);
    eps_reg = eps & 16'hffff;
    @(posedge clk_i);
    cfg_idx_i <= REG_CHANNELS;
    cfg_data_i <= 21'(ch);
    ch_reg = ch & 11'h7ff;
    @(posedge clk_i);
    cfg_idx_i <= REG_PIXELS;
    cfg_data_i <= 21'(px);
    px_reg = px & 21'h1fffff;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  // random phase: mostly samples with a sprinkle of reloads
  task automatic run_phase(int eps, int ch, int px, int count);
    drain_all();
    write_regs(eps, ch, px);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_load($urandom_range(0, NumCh - 1), pick32(), pick32(), pick32(), pick_var());
      end
      push_sample(pick32());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset registers, gamma and variance extremes, sample extremes
    push_load(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h0);
    push_load(1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    push_load(2, 32'h0, 32'h0001_0000, 32'h0002_0000, 31'h0001_0000);
    push_load(1023, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h1);
    push_sample(32'h7fff_ffff);
    push_sample(32'h8000_0000);
    push_sample(32'h0);
    push_sample(32'hffff_ffff);
    push_sample(32'h0001_0000);

    // directed: zero epsilon, zero variance for each sign of gamma
    drain_all();
    write_regs(0, 3, 2);
    gen_ch = ch_cnt;
    push_load(0, 32'h0001_0000, 32'h0, 32'h0, 31'h0);
    push_load(1, 32'hffff_0000, 32'h0, 32'h0, 31'h0);
    push_load(2, 32'h0, 32'h1234_5678, 32'h7fff_ffff, 31'h0);
    for (int i = 0; i < 6; i++) push_sample(pick32());

    // sender holds here until every expected result has come back
    drain_all();

    // random phases through several register settings and their extremes
    run_phase(0, 1, 3, 100);
    run_phase(65535, 3, 5, 150);
    run_phase(1234, 7, 4, 150);
    run_phase(66, 2047, 1, 250);                  // clamps to the channel limit
    run_phase(200, 5, 2, 150);                    // shrink mid-image, counter past end
    run_phase(0, 0, 0, 80);                       // zero registers clamp to one
    run_phase(500, 4, 21'h1f_ffff, 120);          // pixel count clamps to the limit
    run_phase($urandom_range(0, 65535), 16, NumPx, 150);
    drain_all();
    quiet = 1'b1;
    run_phase(300, 6, 3, 250);

    drain_all();
    $display("covered %0d loads and %0d samples over %0d register settings",
             n_loads, n_samples, n_phases);
    if (err_cnt == 0) begin
      $display("batch_norm_inference: match");
    end else begin
      $display("batch_norm_inference: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bni_pkg.sv
rtl/core/bni_coef.sv
rtl/core/bni_table.sv
rtl/core/bni_datapath.sv
rtl/core/batch_norm_inference.sv
tb/testbench.sv
